[rtl/core/itmc_pkg.sv]
// Shared types, constants and register map of the IMU touch/motion classifier.
// Used by itmc_div, itmc_sqrt and the top level; no dependencies.
package itmc_pkg;

   localparam int unsigned CFG_W    = 17;
   localparam int unsigned NUM_CFG  = 8;
   localparam int unsigned CFG_IW   = $clog2(NUM_CFG);
   localparam int unsigned CSR_AW   = CFG_IW + 2;
   localparam int unsigned CSR_DW   = 32;

   // register indexes
   localparam logic [CFG_IW-1:0] REG_TAP_JERK_MIN       = 3'd0;
   localparam logic [CFG_IW-1:0] REG_TAP_BACKGROUND_MAX = 3'd1;
   localparam logic [CFG_IW-1:0] REG_LIFT_UPWARD_MIN    = 3'd2;
   localparam logic [CFG_IW-1:0] REG_SHAKE_LIN_MIN      = 3'd3;
   localparam logic [CFG_IW-1:0] REG_CONTACT_LIN_MIN    = 3'd4;
   localparam logic [CFG_IW-1:0] REG_CONTACT_LIN_MAX    = 3'd5;
   localparam logic [CFG_IW-1:0] REG_STROKE_GYRO_MAX    = 3'd6;
   localparam logic [CFG_IW-1:0] REG_QUIET_LIN_MAX      = 3'd7;

   localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
      17'd8192, 17'd820, 17'd1229, 17'd4096, 17'd205, 17'd2048, 17'd1000, 17'd123
   };

   // filter time constants and posture limits
   localparam int unsigned GRAVITY_TAU_MS = 150;
   localparam int unsigned FEATURE_TAU_MS = 200;
   localparam int unsigned UPWARD_TAU_MS  = 100;
   localparam logic signed [15:0] FACE_LIMIT      = 16'sd11469;
   localparam logic signed [15:0] NEG_FACE_LIMIT  = -16'sd11469;
   localparam logic signed [15:0] INVERTED_LIMIT  = -16'sd8192;

   // timing constants, ms, and the minimum gravity magnitude
   localparam logic [6:0]  STEP_DEFAULT_MS    = 7'd10;
   localparam logic [31:0] STEP_MAX_MS        = 32'd100;
   localparam logic [15:0] HOLD_MS            = 16'd400;
   localparam logic [15:0] STROKE_HOLD_MS     = 16'd1300;
   localparam logic [31:0] CONTACT_BLOCK_MS   = 32'd800;
   localparam logic [31:0] TAP_REFRACTORY_MS  = 32'd250;
   localparam logic [31:0] LIFT_REFRACTORY_MS = 32'd800;
   localparam logic [31:0] MAG_MIN            = 32'd26844;

   typedef enum logic [1:0] {
      CLS_QUIET, CLS_STROKE, CLS_HELD, CLS_SHAKE
   } cls_type;

   typedef enum logic [1:0] {
      EVT_NONE, EVT_TAP, EVT_LIFT
   } evt_type;

   // iterative divider
   localparam int unsigned DIV_NW = 48;
   localparam int unsigned DIV_DW = 32;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] num;
      logic [DIV_DW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_NW-1:0] quo;
   } div_rsp_type;

   // iterative square root
   localparam int unsigned SQ_RW = 64;
   localparam int unsigned SQ_QW = SQ_RW / 2;

   typedef struct packed {
      logic             start;
      logic [SQ_RW-1:0] rad;
   } sqrt_req_type;

   typedef struct packed {
      logic             done;
      logic [SQ_QW-1:0] root;
   } sqrt_rsp_type;

endpackage

[rtl/core/itmc_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on itmc_pkg.
module itmc_div (
   input  logic                clock,
   input  logic                reset,
   input  itmc_pkg::div_req_type req,
   output itmc_pkg::div_rsp_type rsp
);
   import itmc_pkg::*;

   localparam int unsigned CW = $clog2(DIV_NW);
   localparam logic [CW-1:0] LAST = CW'(DIV_NW - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DIV_NW-1:0] quo_ff, quo_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [DIV_DW:0]   trial;
   logic [DIV_DW:0]   diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_NW-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
         quo_in = {quo_ff[DIV_NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

[rtl/core/itmc_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle (floor result).
// Depends on itmc_pkg.
module itmc_sqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  itmc_pkg::sqrt_req_type req,
   output itmc_pkg::sqrt_rsp_type rsp
);
   import itmc_pkg::*;

   localparam int unsigned CW = $clog2(SQ_QW);
   localparam logic [CW-1:0] LAST = CW'(SQ_QW - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [SQ_RW-1:0] rad_ff, rad_in;
   logic [SQ_QW+1:0] rem_ff, rem_in;
   logic [SQ_QW-1:0] root_ff, root_in;
   logic [SQ_QW+3:0] rem_t;
   logic [SQ_QW+3:0] trial;
   logic [SQ_QW+3:0] diff;
   logic             ge;

   always_comb begin
      rem_t   = {rem_ff, rad_ff[SQ_RW-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = rem_t - trial;
      ge      = (rem_t >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = req.rad;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[SQ_QW+1:0] : rem_t[SQ_QW+1:0];
         root_in = {root_ff[SQ_QW-2:0], ge};
         rad_in  = {rad_ff[SQ_RW-3:0], 2'b00};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

[rtl/core/imu_touch_motion_classifier_top.sv]
// Top level of the IMU touch/motion classifier: sequencer, state, CSRs.
// Depends on itmc_pkg, itmc_div and itmc_sqrt.
//
//  channel | ports                       | direction | handshake
//  --------+-----------------------------+-----------+--------------------------------
//  req     | req_time_ms, req_accel_*,   | in        | req_valid / req_stall (ours)
//          | req_gyro_*                  |           |
//  rsp     | rsp_motion_event, ...       | out       | rsp_valid (ours) / rsp_stall
//  csr     | psel penable pwrite paddr   | in/out    | APB, pready tied high
//          | pwdata prdata pready        |           |
//
// Sample processing is set by the bit-serial divider (six filters and three posture
//  components) and the square root unit (four roots); a seeding sample needs only the
//  posture root and at most the three posture divides.
// req_stall is high whenever the sequencer is busy with a transaction.
// The finished result sits in an output register; the next transaction is taken
//  while it waits, and only the final publish step waits on rsp_stall.
// Reset is synchronous and clears all classifier state and the CSRs to defaults.
module imu_touch_motion_classifier_top (
   input  logic                                clock,
   input  logic                                reset,
   // sample input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [31:0]                         req_time_ms,
   input  logic signed [15:0]                  req_accel_x,
   input  logic signed [15:0]                  req_accel_y,
   input  logic signed [15:0]                  req_accel_z,
   input  logic signed [15:0]                  req_gyro_x,
   input  logic signed [15:0]                  req_gyro_y,
   input  logic signed [15:0]                  req_gyro_z,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_motion_event,
   output logic [1:0]                          rsp_activity_class,
   output logic signed [15:0]                  rsp_up_unit_x,
   output logic signed [15:0]                  rsp_up_unit_y,
   output logic signed [15:0]                  rsp_up_unit_z,
   output logic                                rsp_face_up,
   output logic                                rsp_face_down,
   output logic                                rsp_upside_down,
   // CSR port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [itmc_pkg::CSR_AW-1:0]         paddr,
   input  logic [itmc_pkg::CSR_DW-1:0]         pwdata,
   output logic [itmc_pkg::CSR_DW-1:0]         prdata,
   output logic                                pready
);
   import itmc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_STEP, S_EMA_MUL, S_EMA_DIV, S_EMA_WAIT, S_SQ, S_SQRT, S_SQRT_WAIT,
      S_PDIV, S_PDIV_WAIT, S_FLAGS, S_UP, S_TAP, S_ACT, S_LIFT, S_PUBLISH
   } state_type;

   // which sum of squares feeds the root unit
   typedef enum logic [1:0] {
      SQ_POST, SQ_LIN, SQ_GYR, SQ_JERK
   } sqsel_type;

   // filter slots: three gravity axes, then linear, gyro, upward
   localparam logic [2:0] E_GRAV_LAST = 3'd2;
   localparam logic [2:0] E_LIN       = 3'd3;
   localparam logic [2:0] E_GYR       = 3'd4;
   localparam logic [2:0] E_UP        = 3'd5;

   // ---------------- CSRs ----------------
   logic [CFG_W-1:0]  cfg_ff [NUM_CFG];
   logic [CFG_IW-1:0] csr_idx;
   logic              csr_wr;

   assign csr_idx = paddr[CSR_AW-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;
   assign pready  = 1'b1;
   assign prdata  = CSR_DW'(cfg_ff[csr_idx]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr) begin
         cfg_ff[csr_idx] <= pwdata[CFG_W-1:0];
      end
   end

   // thresholds scaled by 256 for comparison against the filters
   function automatic logic signed [33:0] thr256(input logic [CFG_W-1:0] v);
      thr256 = $signed({9'b0, v, 8'b0});
   endfunction

   // ---------------- latched sample ----------------
   logic                req_accept;
   logic [31:0]         smp_time_ff;
   logic signed [15:0]  smp_acc_ff [3];
   logic signed [15:0]  smp_gyr_ff [3];

   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         smp_time_ff   <= req_time_ms;
         smp_acc_ff[0] <= req_accel_x;
         smp_acc_ff[1] <= req_accel_y;
         smp_acc_ff[2] <= req_accel_z;
         smp_gyr_ff[0] <= req_gyro_x;
         smp_gyr_ff[1] <= req_gyro_y;
         smp_gyr_ff[2] <= req_gyro_z;
      end
   end

   // ---------------- classifier state ----------------
   state_type          state_ff, state_in;
   logic               seeded_ff, seeded_in;
   logic               seeding_ff, seeding_in;
   logic signed [31:0] grav_ff [3];
   logic signed [31:0] grav_in [3];
   logic signed [15:0] prev_ff [3];
   logic signed [15:0] prev_in [3];
   logic [31:0]        last_ff, last_in;
   logic [31:0]        mono_ff, mono_in;
   logic signed [31:0] linf_ff, linf_in;
   logic signed [31:0] gyrf_ff, gyrf_in;
   logic signed [31:0] upf_ff, upf_in;
   logic signed [15:0] unit_ff [3];
   logic signed [15:0] unit_in [3];
   logic [2:0]         flags_ff, flags_in;
   logic [31:0]        tapblk_ff, tapblk_in;
   logic [31:0]        liftblk_ff, liftblk_in;
   logic [31:0]        conblk_ff, conblk_in;
   cls_type            cand_ff, cand_in;
   logic [15:0]        hold_ff, hold_in;
   cls_type            settled_ff, settled_in;
   logic               left_ff, left_in;
   evt_type            event_ff, event_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   evt_type            out_event_ff, out_event_in;
   cls_type            out_cls_ff, out_cls_in;
   logic signed [15:0] out_unit_ff [3];
   logic signed [15:0] out_unit_in [3];
   logic [2:0]         out_flags_ff, out_flags_in;

   // work registers of the sequencer
   logic [6:0]         dt_ff, dt_in;
   logic [1:0]         idx_ff, idx_in;
   logic [2:0]         eidx_ff, eidx_in;
   sqsel_type          sqsel_ff, sqsel_in;
   logic [63:0]        acc_ff, acc_in;
   logic signed [33:0] up_ff, up_in;
   logic [64:0]        prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic [31:0]        mag_ff, mag_in;
   logic [17:0]        lin_ff, lin_in;
   logic [17:0]        gyr_ff, gyr_in;
   logic [17:0]        jerk_ff, jerk_in;

   // ---------------- shared units ----------------
   div_req_type  div_req;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   itmc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   itmc_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   logic [32:0] mul_a;
   logic [31:0] mul_b;
   logic [64:0] mul_p;

   assign mul_p = mul_a * mul_b;

   // ---------------- datapath helpers ----------------
   logic signed [32:0] grav_rnd [3];
   logic signed [17:0] lin_vec [3];   // accel minus rounded gravity
   logic signed [16:0] jerk_vec [3];  // accel minus previous accel

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         grav_rnd[i] = ($signed({grav_ff[i][31], grav_ff[i]}) + 33'sd32768) >>> 16;
         lin_vec[i]  = 18'(smp_acc_ff[i]) - grav_rnd[i][17:0];
         jerk_vec[i] = 17'(smp_acc_ff[i]) - 17'(prev_ff[i]);
      end
   end

   // square operand
   logic signed [32:0] sq_elem;
   logic [32:0]        sq_abs;

   always_comb begin
      unique case (sqsel_ff)
         SQ_POST: sq_elem = 33'(grav_ff[idx_ff]);
         SQ_LIN:  sq_elem = 33'(lin_vec[idx_ff]);
         SQ_GYR:  sq_elem = 33'(smp_gyr_ff[idx_ff]);
         SQ_JERK: sq_elem = 33'(jerk_vec[idx_ff]);
         default: sq_elem = '0;
      endcase
      sq_abs = sq_elem[32] ? -sq_elem : sq_elem;
   end

   // filter slot selection
   logic signed [31:0] ema_cur;
   logic signed [33:0] ema_tgt;
   logic signed [33:0] ema_diff;
   logic [32:0]        ema_mag;
   logic [31:0]        ema_den;
   logic signed [33:0] ema_new;
   logic signed [33:0] ema_d;
   logic signed [33:0] up_div;
   logic signed [33:0] up_neg;

   always_comb begin
      up_neg = -up_ff;
      up_div = up_ff[33] ? -(up_neg >>> 6) : (up_ff >>> 6);
      unique case (eidx_ff)
         3'd0, 3'd1, 3'd2: begin
            ema_cur = grav_ff[eidx_ff[1:0]];
            ema_tgt = 34'($signed({smp_acc_ff[eidx_ff[1:0]], 16'h0000}));
            ema_den = 32'(GRAVITY_TAU_MS);
         end
         E_LIN: begin
            ema_cur = linf_ff;
            ema_tgt = $signed(34'({lin_ff, 8'h00}));
            ema_den = 32'(FEATURE_TAU_MS);
         end
         E_GYR: begin
            ema_cur = gyrf_ff;
            ema_tgt = $signed(34'({gyr_ff, 8'h00}));
            ema_den = 32'(FEATURE_TAU_MS);
         end
         default: begin
            ema_cur = upf_ff;
            ema_tgt = up_div;
            ema_den = 32'(UPWARD_TAU_MS);
         end
      endcase
      ema_den  = ema_den + 32'(dt_ff);
      ema_diff = ema_tgt - 34'(ema_cur);
      ema_mag  = ema_diff[33] ? 33'(-ema_diff) : 33'(ema_diff);
      ema_d    = $signed(34'(div_rsp.quo[32:0]));
      ema_new  = 34'(ema_cur) + (neg_ff ? -ema_d : ema_d);
   end

   // posture component magnitude
   logic signed [32:0] pg_s;
   logic [31:0]        pg_abs;
   logic [15:0]        pq;

   always_comb begin
      pg_s   = 33'(grav_ff[idx_ff]);
      pg_abs = pg_s[32] ? 32'(-pg_s) : pg_s[31:0];
      pq     = div_rsp.quo[15:0];
   end

   // step derivation
   logic [31:0] dt_raw;
   logic [6:0]  dt_new;

   always_comb begin
      dt_raw = smp_time_ff - last_ff;
      dt_new = (dt_raw == 32'd0 || dt_raw > STEP_MAX_MS) ? STEP_DEFAULT_MS : dt_raw[6:0];
   end

   // activity classification of this sample
   logic signed [33:0] linf_s, gyrf_s, upf_s;
   cls_type            act_now;
   logic [16:0]        hold_sum;
   cls_type            act_cand;
   logic [15:0]        act_hold;
   logic [15:0]        act_need;
   logic               tap_fire;
   logic               up_sign;
   logic [16:0]        l_abs;
   logic [15:0]        u_abs;

   always_comb begin
      linf_s = 34'(linf_ff);
      gyrf_s = 34'(gyrf_ff);
      upf_s  = 34'(upf_ff);
      priority if (linf_s >= thr256(cfg_ff[REG_SHAKE_LIN_MIN])) begin
         act_now = CLS_SHAKE;
      end else if (mono_ff < conblk_ff) begin
         act_now = CLS_QUIET;
      end else if (linf_s >= thr256(cfg_ff[REG_CONTACT_LIN_MIN]) &&
                   linf_s <  thr256(cfg_ff[REG_CONTACT_LIN_MAX])) begin
         act_now = (gyrf_s < thr256(cfg_ff[REG_STROKE_GYRO_MAX])) ? CLS_STROKE : CLS_HELD;
      end else if (linf_s > thr256(cfg_ff[REG_QUIET_LIN_MAX])) begin
         act_now = cand_ff;
      end else begin
         act_now = CLS_QUIET;
      end
      hold_sum = 17'(hold_ff) + 17'(dt_ff);
      if (act_now == cand_ff) begin
         act_cand = cand_ff;
         act_hold = hold_sum[16] ? 16'hFFFF : hold_sum[15:0];
      end else begin
         act_cand = act_now;
         act_hold = '0;
      end
      act_need = (act_cand == CLS_STROKE) ? STROKE_HOLD_MS : HOLD_MS;

      tap_fire = !(mono_ff < tapblk_ff || mono_ff < liftblk_ff) &&
                 (jerk_ff >= 18'(cfg_ff[REG_TAP_JERK_MIN])) &&
                 (linf_s <= thr256(cfg_ff[REG_TAP_BACKGROUND_MAX]));

      l_abs   = lin_vec[idx_ff][17] ? 17'(-lin_vec[idx_ff]) : lin_vec[idx_ff][16:0];
      u_abs   = unit_ff[idx_ff][15] ? 16'(-unit_ff[idx_ff]) : unit_ff[idx_ff];
      up_sign = lin_vec[idx_ff][17] ^ unit_ff[idx_ff][15];
   end

   // multiplier operands
   always_comb begin
      unique case (state_ff)
         S_EMA_MUL: begin
            mul_a = ema_mag;
            mul_b = 32'(dt_ff);
         end
         S_UP: begin
            mul_a = 33'(l_abs);
            mul_b = 32'(u_abs);
         end
         default: begin
            mul_a = sq_abs;
            mul_b = sq_abs[31:0];
         end
      endcase
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      seeded_in    = seeded_ff;
      seeding_in   = seeding_ff;
      grav_in      = grav_ff;
      prev_in      = prev_ff;
      last_in      = last_ff;
      mono_in      = mono_ff;
      linf_in      = linf_ff;
      gyrf_in      = gyrf_ff;
      upf_in       = upf_ff;
      unit_in      = unit_ff;
      flags_in     = flags_ff;
      tapblk_in    = tapblk_ff;
      liftblk_in   = liftblk_ff;
      conblk_in    = conblk_ff;
      cand_in      = cand_ff;
      hold_in      = hold_ff;
      settled_in   = settled_ff;
      left_in      = left_ff;
      event_in     = event_ff;
      out_event_in = out_event_ff;
      out_cls_in   = out_cls_ff;
      out_unit_in  = out_unit_ff;
      out_flags_in = out_flags_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      dt_in        = dt_ff;
      idx_in       = idx_ff;
      eidx_in      = eidx_ff;
      sqsel_in     = sqsel_ff;
      acc_in       = acc_ff;
      up_in        = up_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      lin_in       = lin_ff;
      gyr_in       = gyr_ff;
      jerk_in      = jerk_ff;
      div_req      = '0;
      sqrt_req     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_STEP;
            end
         end

         S_STEP: begin
            event_in = EVT_NONE;
            if (!seeded_ff) begin
               // first sample seeds gravity straight from the accelerometer
               for (int i = 0; i < 3; i++) begin
                  grav_in[i] = $signed({smp_acc_ff[i], 16'h0000});
                  prev_in[i] = smp_acc_ff[i];
               end
               seeded_in  = 1'b1;
               seeding_in = 1'b1;
               last_in    = smp_time_ff;
               mono_in    = smp_time_ff;
               sqsel_in   = SQ_POST;
               idx_in     = '0;
               acc_in     = '0;
               state_in   = S_SQ;
            end else begin
               seeding_in = 1'b0;
               dt_in      = dt_new;
               last_in    = smp_time_ff;
               mono_in    = mono_ff + 32'(dt_new);
               eidx_in    = '0;
               state_in   = S_EMA_MUL;
            end
         end

         S_EMA_MUL: begin
            prod_in  = mul_p;
            neg_in   = ema_diff[33];
            state_in = S_EMA_DIV;
         end

         S_EMA_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = prod_ff[DIV_NW-1:0];
            div_req.den   = ema_den;
            state_in      = S_EMA_WAIT;
         end

         S_EMA_WAIT: begin
            if (div_rsp.done) begin
               unique case (eidx_ff)
                  3'd0, 3'd1, 3'd2: grav_in[eidx_ff[1:0]] = ema_new[31:0];
                  E_LIN:            linf_in = ema_new[31:0];
                  E_GYR:            gyrf_in = ema_new[31:0];
                  default:          upf_in  = ema_new[31:0];
               endcase
               priority if (eidx_ff == E_GRAV_LAST) begin
                  sqsel_in = SQ_POST;
                  idx_in   = '0;
                  acc_in   = '0;
                  state_in = S_SQ;
               end else if (eidx_ff == E_UP) begin
                  state_in = S_TAP;
               end else begin
                  eidx_in  = eidx_ff + 3'd1;
                  state_in = S_EMA_MUL;
               end
            end
         end

         S_SQ: begin
            acc_in = acc_ff + mul_p[63:0];
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd2) begin
               state_in = S_SQRT;
            end
         end

         S_SQRT: begin
            sqrt_req.start = 1'b1;
            sqrt_req.rad   = acc_ff;
            state_in       = S_SQRT_WAIT;
         end

         S_SQRT_WAIT: begin
            if (sqrt_rsp.done) begin
               idx_in = '0;
               acc_in = '0;
               unique case (sqsel_ff)
                  SQ_POST: begin
                     mag_in = sqrt_rsp.root;
                     if (sqrt_rsp.root < MAG_MIN) begin
                        // too small to normalize: posture holds
                        if (seeding_ff) begin
                           state_in = S_PUBLISH;
                        end else begin
                           up_in    = '0;
                           state_in = S_UP;
                        end
                     end else begin
                        state_in = S_PDIV;
                     end
                  end
                  SQ_LIN: begin
                     lin_in   = sqrt_rsp.root[17:0];
                     sqsel_in = SQ_GYR;
                     state_in = S_SQ;
                  end
                  SQ_GYR: begin
                     gyr_in   = sqrt_rsp.root[17:0];
                     sqsel_in = SQ_JERK;
                     state_in = S_SQ;
                  end
                  default: begin
                     jerk_in  = sqrt_rsp.root[17:0];
                     eidx_in  = E_LIN;
                     state_in = S_EMA_MUL;
                  end
               endcase
            end
         end

         S_PDIV: begin
            // round(|g| * 16384 / mag), halves away from zero
            div_req.start = 1'b1;
            div_req.num   = DIV_NW'({pg_abs, 14'h0000}) + DIV_NW'(mag_ff >> 1);
            div_req.den   = mag_ff;
            state_in      = S_PDIV_WAIT;
         end

         S_PDIV_WAIT: begin
            if (div_rsp.done) begin
               unit_in[idx_ff] = pg_s[32] ? -$signed(pq) : $signed(pq);
               idx_in          = idx_ff + 2'd1;
               state_in        = (idx_ff == 2'd2) ? S_FLAGS : S_PDIV;
            end
         end

         S_FLAGS: begin
            flags_in[0] = (unit_ff[2] > FACE_LIMIT);
            flags_in[1] = (unit_ff[2] < NEG_FACE_LIMIT);
            flags_in[2] = (unit_ff[1] < INVERTED_LIMIT);
            idx_in      = '0;
            up_in       = '0;
            state_in    = seeding_ff ? S_PUBLISH : S_UP;
         end

         S_UP: begin
            up_in  = up_ff + (up_sign ? -34'(mul_p[31:0]) : 34'(mul_p[31:0]));
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd2) begin
               sqsel_in = SQ_LIN;
               idx_in   = '0;
               acc_in   = '0;
               state_in = S_SQ;
            end
         end

         S_TAP: begin
            if (tap_fire) begin
               event_in  = EVT_TAP;
               tapblk_in = mono_ff + TAP_REFRACTORY_MS;
               conblk_in = mono_ff + CONTACT_BLOCK_MS;
            end
            state_in = S_ACT;
         end

         S_ACT: begin
            cand_in = act_cand;
            hold_in = act_hold;
            if (act_cand != settled_ff && act_hold >= act_need) begin
               if (settled_ff == CLS_QUIET && (act_cand == CLS_HELD || act_cand == CLS_SHAKE)) begin
                  left_in = 1'b1;
               end
               settled_in = act_cand;
            end
            state_in = S_LIFT;
         end

         S_LIFT: begin
            left_in = 1'b0;
            if (event_ff == EVT_NONE && !(mono_ff < liftblk_ff)) begin
               if (upf_s >= thr256(cfg_ff[REG_LIFT_UPWARD_MIN]) || left_ff) begin
                  event_in   = EVT_LIFT;
                  liftblk_in = mono_ff + LIFT_REFRACTORY_MS;
               end
            end
            for (int i = 0; i < 3; i++) begin
               prev_in[i] = smp_acc_ff[i];
            end
            state_in = S_PUBLISH;
         end

         S_PUBLISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_event_in = event_ff;
               out_cls_in   = settled_ff;
               out_unit_in  = unit_ff;
               out_flags_in = flags_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seeded_ff    <= 1'b0;
         seeding_ff   <= 1'b0;
         grav_ff      <= '{default: '0};
         prev_ff      <= '{default: '0};
         last_ff      <= '0;
         mono_ff      <= '0;
         linf_ff      <= '0;
         gyrf_ff      <= '0;
         upf_ff       <= '0;
         unit_ff      <= '{default: '0};
         flags_ff     <= '0;
         tapblk_ff    <= '0;
         liftblk_ff   <= '0;
         conblk_ff    <= '0;
         cand_ff      <= CLS_QUIET;
         hold_ff      <= '0;
         settled_ff   <= CLS_QUIET;
         left_ff      <= 1'b0;
         event_ff     <= EVT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         seeding_ff   <= seeding_in;
         grav_ff      <= grav_in;
         prev_ff      <= prev_in;
         last_ff      <= last_in;
         mono_ff      <= mono_in;
         linf_ff      <= linf_in;
         gyrf_ff      <= gyrf_in;
         upf_ff       <= upf_in;
         unit_ff      <= unit_in;
         flags_ff     <= flags_in;
         tapblk_ff    <= tapblk_in;
         liftblk_ff   <= liftblk_in;
         conblk_ff    <= conblk_in;
         cand_ff      <= cand_in;
         hold_ff      <= hold_in;
         settled_ff   <= settled_in;
         left_ff      <= left_in;
         event_ff     <= event_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and work registers, no reset needed
   always_ff @(posedge clock) begin
      out_event_ff <= out_event_in;
      out_cls_ff   <= out_cls_in;
      out_unit_ff  <= out_unit_in;
      out_flags_ff <= out_flags_in;
      dt_ff        <= dt_in;
      idx_ff       <= idx_in;
      eidx_ff      <= eidx_in;
      sqsel_ff     <= sqsel_in;
      acc_ff       <= acc_in;
      up_ff        <= up_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      lin_ff       <= lin_in;
      gyr_ff       <= gyr_in;
      jerk_ff      <= jerk_in;
   end

   // ---------------- ports ----------------
   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motion_event   = out_event_ff;
   assign rsp_activity_class = out_cls_ff;
   assign rsp_up_unit_x      = out_unit_ff[0];
   assign rsp_up_unit_y      = out_unit_ff[1];
   assign rsp_up_unit_z      = out_unit_ff[2];
   assign rsp_face_up        = out_flags_ff[0];
   assign rsp_face_down      = out_flags_ff[1];
   assign rsp_upside_down    = out_flags_ff[2];

endmodule

[tb/imu_touch_motion_classifier_top_test.sv]
`timescale 1ns / 100ps
// Self-checking test of imu_touch_motion_classifier_top: directed table, then random
// sample streams scored against a cycle-free motion predictor. Depends on itmc_pkg.
module imu_touch_motion_classifier_top_test;
   import itmc_pkg::*;

   localparam int N_RANDOM   = 1830;
   localparam int WATCHDOG   = 20000;  // sequencer time per sample plus stalls, with margin
   localparam int DRAIN_WAIT = 800;    // one sample's worth of sequencer time

   logic clock, reset;
   logic req_valid, req_stall;
   logic [31:0] req_time_ms;
   logic signed [15:0] req_accel_x, req_accel_y, req_accel_z;
   logic signed [15:0] req_gyro_x, req_gyro_y, req_gyro_z;
   logic rsp_valid, rsp_stall;
   logic [1:0] rsp_motion_event, rsp_activity_class;
   logic signed [15:0] rsp_up_unit_x, rsp_up_unit_y, rsp_up_unit_z;
   logic rsp_face_up, rsp_face_down, rsp_upside_down;
   logic psel, penable, pwrite, pready;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata, prdata;

   imu_touch_motion_classifier_top u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // one sample and one classification, as the ports carry them
   typedef struct {
      logic [31:0]        stamp;
      logic signed [15:0] acc [3];
      logic signed [15:0] gyr [3];
   } sample_type;

   typedef struct {
      evt_type            evt;
      cls_type            cls;
      logic signed [15:0] up [3];
      logic               fup, fdn, inv;
   } verdict_type;

   // ---------------------------------------------------------------------------
   // Predictor state (mirror of the classifier)
   // ---------------------------------------------------------------------------
   logic [16:0]    thr [NUM_CFG];
   bit             seeded;
   int             grav [3];
   int             prev_acc [3];
   int unsigned    last_stamp, mono;
   int             lin_f, gyr_f, upw_f;
   int             up_vec [3];
   logic [2:0]     pflags;
   int unsigned    tap_until, lift_until, contact_until;
   cls_type        cand_cls, settled_cls;
   int unsigned    cand_hold;
   bit             left_rest;

   verdict_type    pending_verdicts [$];
   int             errors;
   int             wd_count;

   function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned sqr(longint v);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      return m * m;
   endfunction

   function automatic int lowpass(int f, longint tgt, int unsigned dt, longint tau);
      longint d;
      d = (tgt - longint'(f)) * longint'(dt) / (tau + longint'(dt));
      return int'(longint'(f) + d);
   endfunction

   function automatic longint grav_rounded(int g);
      longint q;
      q = longint'(g) + 32768;
      if (q >= 0) return q / 65536;
      return -((-q + 65535) / 65536);
   endfunction

   task automatic update_posture();
      longint mag, g, m, n;
      mag = longint'(isqrt(sqr(grav[0]) + sqr(grav[1]) + sqr(grav[2])));
      if (mag < longint'(MAG_MIN)) return;
      for (int i = 0; i < 3; i++) begin
         g = grav[i];
         m = (g < 0) ? -g : g;
         n = (m * 16384 + mag / 2) / mag;
         up_vec[i] = int'((g < 0) ? -n : n);
      end
      pflags = '0;
      if (up_vec[2] > int'(FACE_LIMIT)) pflags[0] = 1'b1;
      if (up_vec[2] < -int'(FACE_LIMIT)) pflags[1] = 1'b1;
      if (up_vec[1] < int'(INVERTED_LIMIT)) pflags[2] = 1'b1;
   endtask

   task automatic clear_classifier();
      for (int i = 0; i < NUM_CFG; i++) thr[i] = CFG_RESET[i];
      seeded = 0;
      for (int i = 0; i < 3; i++) begin
         grav[i] = 0; prev_acc[i] = 0; up_vec[i] = 0;
      end
      last_stamp = 0; mono = 0;
      lin_f = 0; gyr_f = 0; upw_f = 0; pflags = '0;
      tap_until = 0; lift_until = 0; contact_until = 0;
      cand_cls = CLS_QUIET; cand_hold = 0; settled_cls = CLS_QUIET; left_rest = 0;
   endtask

   function automatic longint thr256(int idx);
      return longint'(thr[idx]) * 256;
   endfunction

   task automatic classify_sample(input sample_type s, output verdict_type v);
      int          a [3], w [3];
      longint      l [3], up, lin, gy, jerk;
      int unsigned dt, need;
      cls_type     now_cls;
      evt_type     evt;
      bit          lr;
      evt = EVT_NONE;
      for (int i = 0; i < 3; i++) begin
         a[i] = s.acc[i]; w[i] = s.gyr[i];
      end
      if (!seeded) begin
         for (int i = 0; i < 3; i++) begin
            grav[i] = a[i] * 65536; prev_acc[i] = a[i];
         end
         seeded = 1; last_stamp = s.stamp; mono = s.stamp;
         update_posture();
      end else begin
         dt = s.stamp - last_stamp;
         if (dt == 0 || dt > STEP_MAX_MS) dt = STEP_DEFAULT_MS;
         last_stamp = s.stamp;
         mono += dt;
         for (int i = 0; i < 3; i++)
            grav[i] = lowpass(grav[i], longint'(a[i]) * 65536, dt, GRAVITY_TAU_MS);
         update_posture();
         up = 0;
         for (int i = 0; i < 3; i++) begin
            l[i] = longint'(a[i]) - grav_rounded(grav[i]);
            up += l[i] * up_vec[i];
         end
         lin = longint'(isqrt(sqr(l[0]) + sqr(l[1]) + sqr(l[2])));
         gy  = longint'(isqrt(sqr(w[0]) + sqr(w[1]) + sqr(w[2])));
         lin_f = lowpass(lin_f, lin * 256, dt, FEATURE_TAU_MS);
         gyr_f = lowpass(gyr_f, gy * 256, dt, FEATURE_TAU_MS);
         upw_f = lowpass(upw_f, up / 64, dt, UPWARD_TAU_MS);

         // tap: jerk over threshold on a calm background, outside both refractories
         jerk = longint'(isqrt(sqr(a[0] - prev_acc[0]) + sqr(a[1] - prev_acc[1]) +
                               sqr(a[2] - prev_acc[2])));
         if (!(mono < tap_until || mono < lift_until) &&
             jerk >= longint'(thr[REG_TAP_JERK_MIN]) &&
             longint'(lin_f) <= thr256(REG_TAP_BACKGROUND_MAX)) begin
            evt = EVT_TAP;
            tap_until = mono + TAP_REFRACTORY_MS;
            contact_until = mono + CONTACT_BLOCK_MS;
         end

         // activity with hold-time hysteresis
         now_cls = CLS_QUIET;
         if (longint'(lin_f) >= thr256(REG_SHAKE_LIN_MIN)) now_cls = CLS_SHAKE;
         else if (mono < contact_until) now_cls = CLS_QUIET;
         else if (longint'(lin_f) >= thr256(REG_CONTACT_LIN_MIN) &&
                  longint'(lin_f) < thr256(REG_CONTACT_LIN_MAX))
            now_cls = (longint'(gyr_f) < thr256(REG_STROKE_GYRO_MAX)) ? CLS_STROKE : CLS_HELD;
         else if (longint'(lin_f) > thr256(REG_QUIET_LIN_MAX)) now_cls = cand_cls;

         if (now_cls == cand_cls) begin
            cand_hold += dt;
            if (cand_hold > 32'hFFFF) cand_hold = 32'hFFFF;
         end else begin
            cand_cls = now_cls; cand_hold = 0;
         end
         need = (cand_cls == CLS_STROKE) ? STROKE_HOLD_MS : HOLD_MS;
         if (cand_cls != settled_cls && cand_hold >= need) begin
            if (settled_cls == CLS_QUIET && (cand_cls == CLS_HELD || cand_cls == CLS_SHAKE))
               left_rest = 1;
            settled_cls = cand_cls;
         end

         // lift: fast path on upward accel, slow path on leaving rest
         lr = left_rest;
         left_rest = 0;
         if (evt == EVT_NONE && !(mono < lift_until)) begin
            if (longint'(upw_f) >= thr256(REG_LIFT_UPWARD_MIN) || lr) begin
               evt = EVT_LIFT;
               lift_until = mono + LIFT_REFRACTORY_MS;
            end
         end
         for (int i = 0; i < 3; i++) prev_acc[i] = a[i];
      end
      v.evt = evt;
      v.cls = settled_cls;
      for (int i = 0; i < 3; i++) v.up[i] = up_vec[i][15:0];
      v.fup = pflags[0]; v.fdn = pflags[1]; v.inv = pflags[2];
   endtask

   // ---------------------------------------------------------------------------
   // Receiver: own stall pattern, scoring each transaction
   // ---------------------------------------------------------------------------
   int stall_mode;  // 0 none, 1 light, 2 heavy

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) == 0);
         default: rsp_stall <= ($urandom_range(0, 2) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         wd_count <= 0;
      else
         wd_count <= wd_count + 1;
   end

   always @(posedge clock) begin
      verdict_type ev;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result transaction", $time);
            errors++;
         end else begin
            ev = pending_verdicts.pop_front();
            if (rsp_motion_event !== ev.evt) begin
               $display("%0t: motion_event exp %0d got %0d", $time, ev.evt, rsp_motion_event);
               errors++;
            end
            if (rsp_activity_class !== ev.cls) begin
               $display("%0t: activity_class exp %0d got %0d", $time, ev.cls,
                        rsp_activity_class);
               errors++;
            end
            if (rsp_up_unit_x !== ev.up[0] || rsp_up_unit_y !== ev.up[1] ||
                rsp_up_unit_z !== ev.up[2]) begin
               $display("%0t: up_unit exp %0d %0d %0d got %0d %0d %0d", $time,
                        ev.up[0], ev.up[1], ev.up[2],
                        rsp_up_unit_x, rsp_up_unit_y, rsp_up_unit_z);
               errors++;
            end
            if ({rsp_face_up, rsp_face_down, rsp_upside_down} !== {ev.fup, ev.fdn, ev.inv})
            begin
               $display("%0t: flags up/down/inv exp %b%b%b got %b%b%b", $time,
                        ev.fup, ev.fdn, ev.inv, rsp_face_up, rsp_face_down, rsp_upside_down);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sender and CSR helpers
   // ---------------------------------------------------------------------------
   int burst_left;

   task automatic send_sample(input sample_type s, input bit has_exp, input verdict_type vx);
      verdict_type v;
      // bursts of random length, random gaps between
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 30)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_time_ms <= s.stamp;
      req_accel_x <= s.acc[0]; req_accel_y <= s.acc[1]; req_accel_z <= s.acc[2];
      req_gyro_x  <= s.gyr[0]; req_gyro_y  <= s.gyr[1]; req_gyro_z  <= s.gyr[2];
      do @(posedge clock); while (!(req_valid && !req_stall));
      classify_sample(s, v);
      if (has_exp && (v.evt != vx.evt || v.cls != vx.cls || v.up != vx.up ||
                      {v.fup, v.fdn, v.inv} != {vx.fup, vx.fdn, vx.inv})) begin
         $display("%0t: table row disagrees with prediction", $time);
         errors++;
      end
      pending_verdicts.push_back(has_exp ? vx : v);
      @(negedge clock);
      req_valid <= 1'b0;
      // the block is busy for many cycles anyway; keep the next drive off this step
      @(negedge clock);
   endtask

   task automatic drain();
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CFG_IW-1:0] idx, input logic [16:0] val);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {idx, 2'b00}; pwdata <= {15'd0, val};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      thr[idx] = val;
      @(negedge clock);
   endtask

   // random sample around a resting pose, with occasional hits and wide values
   function automatic sample_type rand_sample(ref int unsigned clk_ms, input int flavor);
      sample_type s;
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) clk_ms += $urandom_range(5, 20);
      else if (r < 90) clk_ms += 0;
      else if (r < 95) clk_ms += $urandom_range(101, 5000);
      else clk_ms = $urandom();
      s.stamp = clk_ms;
      for (int i = 0; i < 3; i++) begin
         case (flavor)
            0: s.acc[i] = 16'((i == 2 ? 4096 : 0) + $signed($urandom_range(0, 400)) - 200);
            1: s.acc[i] = 16'((i == 2 ? 4096 : 0) + $signed($urandom_range(0, 6000)) - 3000);
            2: s.acc[i] = ($urandom_range(0, 19) == 0) ? 16'($urandom())
                          : 16'((i == 1 ? -4096 : 0) + $signed($urandom_range(0, 1600)) - 800);
            default: s.acc[i] = 16'($urandom());
         endcase
         s.gyr[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                    : 16'($signed($urandom_range(0, 3000)) - 1500);
      end
      // sharp spike for taps
      if ($urandom_range(0, 24) == 0) s.acc[$urandom_range(0, 2)] += 16'sd12000;
      return s;
   endfunction

   // ---------------------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------------------
   typedef struct {
      sample_type  s;
      bit          has_exp;
      verdict_type vx;
   } row_type;

   function automatic row_type mk(int unsigned t, int ax, int ay, int az,
                                  int gx, int gy, int gz);
      row_type r;
      r.s.stamp = t;
      r.s.acc[0] = 16'(ax); r.s.acc[1] = 16'(ay); r.s.acc[2] = 16'(az);
      r.s.gyr[0] = 16'(gx); r.s.gyr[1] = 16'(gy); r.s.gyr[2] = 16'(gz);
      r.has_exp = 0;
      return r;
   endfunction

   // expectation that can be read straight off: seeding sample, flat pose
   function automatic row_type with_exp(row_type r, evt_type e, cls_type c,
                                        int ux, int uy, int uz, logic [2:0] f);
      r.has_exp = 1;
      r.vx.evt = e; r.vx.cls = c;
      r.vx.up[0] = 16'(ux); r.vx.up[1] = 16'(uy); r.vx.up[2] = 16'(uz);
      r.vx.fup = f[0]; r.vx.fdn = f[1]; r.vx.inv = f[2];
      return r;
   endfunction

   row_type dir_rows [$];

   initial begin
      int unsigned clk_ms;
      int flavor;
      sample_type s;
      verdict_type dummy;

      errors = 0; burst_left = 0; stall_mode = 0;
      reset = 1'b1; req_valid = 1'b0;
      req_time_ms = '0; req_accel_x = '0; req_accel_y = '0; req_accel_z = '0;
      req_gyro_x = '0; req_gyro_y = '0; req_gyro_z = '0;
      rsp_stall = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      clear_classifier();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // seed with 1 g on z: face up, no event, quiet
      dir_rows.push_back(with_exp(mk(100, 0, 0, 4096, 0, 0, 0),
                                  EVT_NONE, CLS_QUIET, 0, 0, 16384, 3'b001));
      dir_rows.push_back(mk(110, 0, 0, 4096, 0, 0, 0));
      dir_rows.push_back(mk(110, 0, 0, 4096, 0, 0, 0));                 // zero step
      dir_rows.push_back(mk(5000, 0, 0, 4096, 0, 0, 0));                // long step
      dir_rows.push_back(mk(5100, 0, 0, 4096, 0, 0, 0));                // max good step
      dir_rows.push_back(mk(5110, 0, 0, 16384, 0, 0, 0));               // tap
      dir_rows.push_back(mk(5120, 0, 0, 4096, 0, 0, 0));                // refractory
      dir_rows.push_back(mk(5130, 32767, 32767, 32767, 32767, 32767, 32767));
      dir_rows.push_back(mk(5140, -32768, -32768, -32768, -32768, -32768, -32768));
      dir_rows.push_back(mk(32'hFFFF_FFF0, 0, -4096, 0, 0, 0, 0));       // near wrap
      dir_rows.push_back(mk(32'h0000_0005, 0, -4096, 0, 0, 0, 0));       // wrapped stamp
      for (int k = 0; k < 8; k++)
         dir_rows.push_back(mk(15 + 20 * k, 0, 0, -4096, 0, 0, 0));     // flip to face down
      for (int k = 0; k < 6; k++)
         dir_rows.push_back(mk(200 + 20 * k, 600 * (k % 2), 0, -4096, 4000, 0, 0));

      stall_mode = 1;
      foreach (dir_rows[k]) send_sample(dir_rows[k].s, dir_rows[k].has_exp, dir_rows[k].vx);
      // pause until every result is in
      drain();

      // random phases with different threshold sets, extremes among them
      clk_ms = 1000;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: for (int r = 0; r < NUM_CFG; r++) csr_write(r[CFG_IW-1:0], 17'h1FFFF);
            1: for (int r = 0; r < NUM_CFG; r++) csr_write(r[CFG_IW-1:0], 17'd0);
            2: for (int r = 0; r < NUM_CFG; r++) csr_write(r[CFG_IW-1:0], CFG_RESET[r]);
            default: for (int r = 0; r < NUM_CFG; r++)
               csr_write(r[CFG_IW-1:0], 17'(CFG_RESET[r] >> $urandom_range(0, 2) <<
                                             $urandom_range(0, 2)));
         endcase
         stall_mode = ph % 3;
         for (int n = 0; n < N_RANDOM / 6; n++) begin
            flavor = (n / 60) % 4;
            if ($urandom_range(0, 9) == 0) flavor = 3;
            s = rand_sample(clk_ms, flavor);
            send_sample(s, 0, dummy);
         end
         drain();
      end

      if (errors == 0)
         $display("imu_touch_motion_classifier_top verification clean");
      else
         $display("imu_touch_motion_classifier_top verification failed");
      $finish;
   end

   initial begin
      wd_count = 0;
      wait (wd_count >= WATCHDOG);
      $display("imu_touch_motion_classifier_top verification failed");
      $finish;
   end

endmodule
